FILE: rtl/core/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types, widths and reset values for the battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int DIFF_W         = 10;
  localparam int PCT_W          = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int PROBE_DEPTH_DEF = 16;

  localparam logic [DIFF_W-1:0]   ALERT_RST     = 10'd100;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd2900;
  localparam logic [DIFF_W-1:0]   DISCH_RST     = 10'd50;

  localparam logic [PCT_W-1:0]    PCT_MAX       = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALERT_DIFF    = 2'd0,
    REG_LOW_THRESHOLD = 2'd1,
    REG_DISCH_DIFF    = 2'd2,
    REG_UNUSED        = 2'd3
  } bvm_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_DIV,
    S_OUT
  } bvm_state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } bvm_ring_ctl_t;

endpackage

FILE: rtl/core/battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// Supply-voltage supervisor: min/max, ring average, low flag and percent.
// ----------------------------------------------------------------------------
// Sequence: accept, memory read (S_READ), divider start (S_START), divide (S_DIV), output load (S_OUT).
// Requests do not overlap: a new request waits until the bit-serial divider is done and the result is loaded.
// in_ready drops on accept and returns once the result is in the output register.
// Reset: synchronous, active low; clears pointer, fill count, sum, min/max and
// loads the register defaults. The sample memory is not cleared.
// ----------------------------------------------------------------------------
module battery_voltage_monitor import bvm_pkg::*; #(
  parameter int PROBE_DEPTH = PROBE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample_mv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_average_mv,
  output logic [SAMPLE_W-1:0]   out_spread_mv,
  output logic                  out_battery_low,
  output logic [PCT_W-1:0]      out_battery_percent,
  output logic [SAMPLE_W-1:0]   out_sample_echo_mv
);

  localparam int SUM_W  = SAMPLE_W + $clog2(PROBE_DEPTH);
  localparam int FILL_W = $clog2(PROBE_DEPTH + 1);

  bvm_state_t state_r, state_nxt;

  logic [DIFF_W-1:0]   alert_r;
  logic [SAMPLE_W-1:0] thr_r;
  logic [DIFF_W-1:0]   disc_r;

  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] min_r;
  logic [SAMPLE_W-1:0] max_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic [SAMPLE_W-1:0] out_spread_r;
  logic                out_low_r;
  logic [PCT_W-1:0]    out_pct_r;
  logic [SAMPLE_W-1:0] out_echo_r;

  bvm_ring_ctl_t       ring_ctl;
  logic [SUM_W-1:0]    ring_sum;
  logic [FILL_W-1:0]   ring_fill;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic                out_load;
  logic                in_fire;

  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] spread;
  logic                low;
  logic [DIFF_W:0]     dis_term;
  logic [DIFF_W-1:0]   chg_diff;
  logic [DIFF_W+1:0]   chg_term;
  logic [DIFF_W:0]     pct_raw;
  logic [PCT_W-1:0]    pct;

  assign in_fire = in_valid && in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alert_r <= ALERT_RST;
      thr_r   <= THRESHOLD_RST;
      disc_r  <= DISCH_RST;
    end else if (cfg_we) begin
      unique case (bvm_reg_t'(cfg_index))
        REG_ALERT_DIFF:    alert_r <= cfg_wdata[DIFF_W-1:0];
        REG_LOW_THRESHOLD: thr_r   <= cfg_wdata[SAMPLE_W-1:0];
        REG_DISCH_DIFF:    disc_r  <= cfg_wdata[DIFF_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_READ;
      S_READ:  state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ring_ctl.rd = 1'b0;
    ring_ctl.wr = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        ring_ctl.rd = in_valid;
      end
      S_READ:  ring_ctl.wr = 1'b1;
      S_START: div_start   = 1'b1;
      S_DIV: ;
      S_OUT:   out_load    = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_sample_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '0;
    end else if (ring_ctl.wr) begin
      if (ring_fill == '0) begin
        min_r <= sample_r;
        max_r <= sample_r;
      end else begin
        if (sample_r < min_r) min_r <= sample_r;
        if (sample_r > max_r) max_r <= sample_r;
      end
    end
  end

  bvm_ring #(
    .DEPTH  (PROBE_DEPTH),
    .SUM_W  (SUM_W),
    .FILL_W (FILL_W)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ring_ctl),
    .sample (state_r == S_IDLE ? in_sample_mv : sample_r),
    .sum    (ring_sum),
    .fill   (ring_fill)
  );

  bvm_div #(
    .SUM_W  (SUM_W),
    .FILL_W (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ring_sum),
    .divisor  (ring_fill),
    .done     (div_done),
    .quotient (div_quo)
  );

  // result evaluation
  assign avg      = div_quo[SAMPLE_W-1:0];
  assign spread   = max_r - min_r;
  assign low      = (spread >= SAMPLE_W'(alert_r)) || (avg < thr_r);
  assign dis_term = {1'b0, alert_r} - {1'b0, spread[DIFF_W-1:0]} + (DIFF_W+1)'(1);
  assign chg_diff = disc_r - spread[DIFF_W-1:0];
  assign chg_term = ({2'b0, chg_diff} << 1) + {2'b0, chg_diff} + (DIFF_W+2)'(1);

  always_comb begin
    priority if (low) begin
      pct_raw = '0;
    end else if (spread > SAMPLE_W'(disc_r)) begin
      pct_raw = {1'b0, dis_term[DIFF_W:1]};
    end else begin
      pct_raw = (DIFF_W+1)'(25) + chg_term[DIFF_W+1:1];
    end
    pct = (pct_raw > (DIFF_W+1)'(PCT_MAX)) ? PCT_MAX : pct_raw[PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r    <= avg;
      out_spread_r <= spread;
      out_low_r    <= low;
      out_pct_r    <= pct;
      out_echo_r   <= sample_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_average_mv      = out_avg_r;
  assign out_spread_mv       = out_spread_r;
  assign out_battery_low     = out_low_r;
  assign out_battery_percent = out_pct_r;
  assign out_sample_echo_mv  = out_echo_r;

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_READ)
    else $error("accept did not start memory read");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= max_r)
    else $error("minimum above maximum");

  a_low_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_low_r |-> out_pct_r == '0)
    else $error("nonzero percent with low flag");

endmodule

FILE: rtl/core/bvm_ring.sv
// ----------------------------------------------------------------------------
// bvm_ring
// Sample history memory with write pointer, fill count and running sum.
// ----------------------------------------------------------------------------
module bvm_ring import bvm_pkg::*; #(
  parameter int DEPTH  = PROBE_DEPTH_DEF,
  parameter int SUM_W  = SAMPLE_W + $clog2(DEPTH),
  parameter int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bvm_ring_ctl_t       ctl,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]    sum,
  output logic [FILL_W-1:0]   fill
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_q;

  logic [IDX_W-1:0]  idx_r,  idx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r,  sum_nxt;
  logic              full;

  assign full = (fill_r == FILL_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_q <= mem[idx_r];
    end
    if (ctl.wr) begin
      mem[idx_r] <= sample;
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (ctl.wr) begin
      idx_nxt = (idx_r == IDX_W'(DEPTH - 1)) ? '0 : idx_r + IDX_W'(1);
      if (full) begin
        sum_nxt = sum_r - SUM_W'(rd_q) + SUM_W'(sample);
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
        sum_nxt  = sum_r + SUM_W'(sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign sum  = sum_r;
  assign fill = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill count beyond depth");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr |=> fill_r != '0)
    else $error("fill count zero after write");

endmodule

FILE: rtl/core/bvm_div.sv
// ----------------------------------------------------------------------------
// bvm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvm_div import bvm_pkg::*; #(
  parameter int SUM_W  = SAMPLE_W + $clog2(PROBE_DEPTH_DEF),
  parameter int FILL_W = $clog2(PROBE_DEPTH_DEF + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [FILL_W-1:0] divisor,
  output logic              done,
  output logic [SUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [FILL_W-1:0] rem_r;
  logic [FILL_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider did not start");

endmodule

FILE: tb/battery_voltage_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_monitor_tb
// Self-checking bench for the supply-voltage supervisor. A queue-fed driver
// issues sample requests, a shadow supervisor predicts every report, and a
// monitor checks the reports in order. Phases vary the register settings and
// the sender idle / receiver stall profiles. Min and max are never cleared
// after reset, so the samples stay in a narrow band until the closing
// full-range phase.
// ----------------------------------------------------------------------------
module battery_voltage_monitor_tb;
  import bvm_pkg::*;

  localparam int RING_DEPTH     = PROBE_DEPTH_DEF;
  localparam int IDX_W          = $clog2(RING_DEPTH);
  localparam int SUM_W          = SAMPLE_W + IDX_W;
  localparam int PCT_BASE       = 25;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 32;
  localparam int PAUSE_CYCLES   = 20;
  localparam int BAND_ITEMS     = 230;
  localparam int WIDE_ITEMS     = 110;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_mv;
    logic [SAMPLE_W-1:0] spread_mv;
    logic                battery_low;
    logic [PCT_W-1:0]    battery_percent;
    logic [SAMPLE_W-1:0] sample_echo_mv;
  } report_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_ALERT_DIFF;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample_mv = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [SAMPLE_W-1:0]   out_average_mv;
  logic [SAMPLE_W-1:0]   out_spread_mv;
  logic                  out_battery_low;
  logic [PCT_W-1:0]      out_battery_percent;
  logic [SAMPLE_W-1:0]   out_sample_echo_mv;

  battery_voltage_monitor uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample_mv        (in_sample_mv),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_average_mv      (out_average_mv),
    .out_spread_mv       (out_spread_mv),
    .out_battery_low     (out_battery_low),
    .out_battery_percent (out_battery_percent),
    .out_sample_echo_mv  (out_sample_echo_mv)
  );

  // shadow supervisor state
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [IDX_W-1:0]    ring_wr_idx;
  logic [IDX_W:0]      ring_fill;
  logic [SUM_W-1:0]    ring_sum;
  logic [SAMPLE_W-1:0] min_mv;
  logic [SAMPLE_W-1:0] max_mv;
  logic [DIFF_W-1:0]   alert_mv;
  logic [SAMPLE_W-1:0] thr_mv;
  logic [DIFF_W-1:0]   disc_mv;

  logic [SAMPLE_W-1:0] pending_samples [$];
  report_t             expected_reports [$];

  int issued_cnt    = 0;
  int checked_cnt   = 0;
  int err_cnt       = 0;
  int n_settings    = 0;
  int n_low         = 0;
  int n_discharging = 0;
  int n_charged     = 0;
  int n_clamped     = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  logic drain_hold  = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic compute_monitor_report(input logic [SAMPLE_W-1:0] s);
    report_t          r;
    logic [IDX_W-1:0] slot;
    int unsigned      avg;
    int unsigned      spread;
    int unsigned      pct;
    slot = ring_wr_idx;
    if (ring_fill == 0) begin
      min_mv = s;
      max_mv = s;
    end else begin
      if (s < min_mv) min_mv = s;
      if (s > max_mv) max_mv = s;
    end
    if (ring_fill >= RING_DEPTH) ring_sum = ring_sum - ring_mem[slot];
    else ring_fill = ring_fill + 1'b1;
    ring_sum       = ring_sum + s;
    ring_mem[slot] = s;
    ring_wr_idx    = (slot == RING_DEPTH - 1) ? '0 : slot + 1'b1;
    avg    = ring_sum / ring_fill;
    spread = max_mv - min_mv;
    r.battery_low = (spread >= alert_mv) || (avg < thr_mv);
    if (r.battery_low) begin
      pct = 0;
      n_low++;
    end else if (spread > disc_mv) begin
      pct = (alert_mv - spread + 1) >> 1;
      n_discharging++;
    end else begin
      pct = PCT_BASE + ((3 * (disc_mv - spread) + 1) >> 1);
      n_charged++;
    end
    if (pct > PCT_MAX) begin
      pct = PCT_MAX;
      n_clamped++;
    end
    r.average_mv      = avg[SAMPLE_W-1:0];
    r.spread_mv       = spread[SAMPLE_W-1:0];
    r.battery_percent = pct[PCT_W-1:0];
    r.sample_echo_mv  = s;
    expected_reports.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] expv,
                                      input logic [SAMPLE_W-1:0] act);
    if (act !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, act);
      err_cnt++;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] band_sample(input int lo, input int hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return lo[SAMPLE_W-1:0];
    if (r == 1) return hi[SAMPLE_W-1:0];
    return SAMPLE_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [SAMPLE_W-1:0] wide_sample();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic write_reg(input bvm_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ALERT_DIFF:    alert_mv = data[DIFF_W-1:0];
      REG_LOW_THRESHOLD: thr_mv   = data;
      REG_DISCH_DIFF:    disc_mv  = data[DIFF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] alert,
                               input logic [CFG_DATA_W-1:0] thr,
                               input logic [CFG_DATA_W-1:0] disc);
    write_reg(REG_ALERT_DIFF, alert);
    write_reg(REG_LOW_THRESHOLD, thr);
    write_reg(REG_DISCH_DIFF, disc);
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || issued_cnt != checked_cnt);
  endtask

  task automatic run_phase(input int n, input int mode, input int lo, input int hi,
                           input bit wide, input bit pause);
    int start;
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 49; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 49; end
      default: begin idle_pct = 12; stall_pct = 12; end
    endcase
    start = issued_cnt;
    for (int i = 0; i < n; i++)
      pending_samples.push_back(wide ? wide_sample() : band_sample(lo, hi));
    if (pause) begin
      while (issued_cnt < start + n / 2) @(posedge clk);
      drain_hold = 1'b1;
      while (issued_cnt != checked_cnt) @(posedge clk);
      repeat (PAUSE_CYCLES) @(posedge clk);
      drain_hold = 1'b0;
    end
    wait_drained();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) compute_monitor_report(in_sample_mv);
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && !drain_hold && $urandom_range(99) >= idle_pct) begin
          in_valid     <= 1'b1;
          in_sample_mv <= pending_samples.pop_front();
          issued_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk) begin : result_check
    report_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report with no request outstanding");
          err_cnt++;
        end else begin
          exp_r = expected_reports.pop_front();
          check_field("average_mv", exp_r.average_mv, out_average_mv);
          check_field("spread_mv", exp_r.spread_mv, out_spread_mv);
          check_field("battery_low", SAMPLE_W'(exp_r.battery_low),
                      SAMPLE_W'(out_battery_low));
          check_field("battery_percent", SAMPLE_W'(exp_r.battery_percent),
                      SAMPLE_W'(out_battery_percent));
          check_field("sample_echo_mv", exp_r.sample_echo_mv, out_sample_echo_mv);
          checked_cnt++;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no request or report moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_seq
    int lo;
    int hi;
    int sp;
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    ring_wr_idx = '0;
    ring_fill   = '0;
    ring_sum    = '0;
    min_mv      = '0;
    max_mv      = '0;
    alert_mv    = ALERT_RST;
    thr_mv      = THRESHOLD_RST;
    disc_mv     = DISCH_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: first sample, charged, discharging, near the alert edge
    pending_samples.push_back(16'd3000); pending_samples.push_back(16'd3000);
    pending_samples.push_back(16'd3010); pending_samples.push_back(16'd3030);
    pending_samples.push_back(16'd3051); pending_samples.push_back(16'd3060);
    pending_samples.push_back(16'd3080); pending_samples.push_back(16'd3099);
    pending_samples.push_back(16'd3099); pending_samples.push_back(16'd3000);
    wait_drained();
    // unmapped index must be ignored; average straddles the threshold
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_LOW_THRESHOLD, 16'd3050);
    repeat (4) pending_samples.push_back(16'd3000);
    repeat (4) pending_samples.push_back(16'd3099);
    wait_drained();
    // spread equal to alert difference
    write_reg(REG_ALERT_DIFF, 16'd99);
    repeat (2) pending_samples.push_back(16'd3050);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      lo = 3000 - 12 * (p + 1);
      hi = 3099 + 12 * (p + 1);
      sp = hi - lo;
      case (p)
        0: apply_setting(CFG_DATA_W'(sp + 250), 16'd3050, CFG_DATA_W'(sp + 40));
        1: apply_setting(CFG_DATA_W'(sp + 40), 16'd2990, CFG_DATA_W'(sp - 30));
        2: apply_setting(16'd0, 16'd3000, 16'd500);
        3: apply_setting(CFG_DATA_W'(sp + 20), 16'd0, 16'd999);
        4: apply_setting(16'd1000, 16'd3060, 16'd0);
        5: apply_setting(16'd1, 16'hFFFF, 16'd0);
        default: begin
          // upper data bits beyond the register width are dropped
          apply_setting(16'hFC00 | CFG_DATA_W'(sp + 100), 16'd3050, CFG_DATA_W'(sp + 5));
          write_reg(REG_UNUSED, 16'h0000);
        end
      endcase
      run_phase(BAND_ITEMS, p % 4, lo, hi, 1'b0, p == 3);
    end

    // full-range samples: field extremes, full ring at max, then at zero
    apply_setting(16'd1000, 16'h8000, 16'd999);
    pending_samples.push_back(16'h0000); pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h5555); pending_samples.push_back(16'hAAAA);
    repeat (RING_DEPTH) pending_samples.push_back(16'hFFFF);
    repeat (RING_DEPTH) pending_samples.push_back(16'h0000);
    run_phase(WIDE_ITEMS, 3, 0, 0, 1'b1, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d expected reports never arrived", expected_reports.size());
      err_cnt++;
    end
    $display("Run covered %0d sample requests over %0d register settings and four idle profiles.",
             issued_cnt, n_settings);
    $display("Predicted reports: %0d low, %0d discharging, %0d charged, %0d percent clamps.",
             n_low, n_discharging, n_charged, n_clamped);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
